@@ src/eft_pkg.sv @@
// shared types, constants and helpers for the euler frame transform
// no dependencies
package eft_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS    = 5;
    localparam int MUL_STEPS    = 28;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CORDIC = 6'b000010,
        ST_MUL_IS = 6'b000100,
        ST_MUL_US = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] turn_atan(input logic [STEP_BITS-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680862;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41721;
            5'd15: r = 32'd20860;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2607;
            5'd19: r = 32'd1303;
            5'd20: r = 32'd651;
            5'd21: r = 32'd325;
            5'd22: r = 32'd162;
            5'd23: r = 32'd81;
            5'd24: r = 32'd40;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd2;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // round to nearest, ties up, dropping 30 fraction bits
    function automatic logic signed [39:0] rnd30(input logic signed [69:0] v);
        logic signed [69:0] t;
        t = v + 70'sd536870912;
        return t[69:30];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [69:0] v);
        logic [31:0] r;
        if (v > 70'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -70'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/eft_cordic.sv @@
// one rotation cordic lane: sin and cos of a binary angle in q30
// depends on eft_pkg
module eft_cordic
    import eft_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic                  o_done,
    output logic signed [31:0]    o_cos,
    output logic signed [31:0]    o_sin
);
    logic                 r_busy, r_flip;
    logic [STEP_BITS-1:0] r_i;
    logic signed [33:0]   r_x, r_y, r_z;
    logic [31:0]          w_turn, w_fold;
    logic                 w_flip;
    logic signed [33:0]   w_xs, w_ys, w_at;

    assign w_turn = {i_angle, {(32 - ANGLE_BITS){1'b0}}};
    assign w_flip = w_turn[31] ^ w_turn[30];
    assign w_fold = w_flip ? (w_turn + 32'h8000_0000) : w_turn;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_at   = signed'({2'b00, turn_atan(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            if (r_i == STEP_BITS'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_i <= r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= 34'(signed'(w_fold));
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = ~r_busy;
    assign o_cos  = r_flip ? -r_x[31:0] : r_x[31:0];
    assign o_sin  = r_flip ? -r_y[31:0] : r_y[31:0];
endmodule

@@ src/eft_div.sv @@
// bit-serial signed divider, quotient truncated toward zero
// depends on eft_pkg; a zero numerator gives zero, else a zero divisor gives an all-ones magnitude
module eft_div
    import eft_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [64:0] o_quo
);
    logic        r_busy, r_neg, r_zero;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] w_sh;

    assign w_sh = {r_rem[31:0], r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_neg  <= i_num[63] ^ i_den[31];
            r_zero <= (i_num == '0);
            r_rem  <= '0;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_done = ~r_busy;
    assign o_quo  = r_zero ? '0 :
                    (r_neg ? -signed'({1'b0, r_q}) : signed'({1'b0, r_q}));
endmodule

@@ src/euler_frame_transform.sv @@
// euler frame transform top level: origin, cordic lanes, shared multiplier, dividers
// depends on eft_pkg, eft_cordic, eft_div
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  s_axis_tdata, one nav sample
//  m_axis    out  m_axis_tvalid/m_axis_tready  m_axis_tdata, one transformed sample
//
// one item at a time from accept to result valid: a start strobe and 30 cordic steps
// (three lanes in parallel), 28 shared-multiplier steps of an issue and an update
// state, a start strobe and 64 divider steps (two dividers in parallel), done state.
// reset is synchronous active low and clears the origin and control. a new item is
// taken while a finished one waits in the output register; a stalled output holds
// the engine in its last state.
module euler_frame_transform
    import eft_pkg::*;
#(
    parameter  int ANGLE_BITS = 16,
    localparam int IN_W       = ((3 * ANGLE_BITS + 288 + 7) / 8) * 8,
    localparam int OUT_W      = ((3 * ANGLE_BITS + 291 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, vel_north, vel_east, vel_down,
    // rate_x, rate_y, rate_z, latitude, longitude, depth_mm
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // rel_x, rel_y, rel_depth, roll_out, pitch_out, yaw_out, vel_u, vel_v,
    // vel_w, roll_rate, pitch_rate, yaw_rate
    output logic [OUT_W-1:0]  m_axis_tdata
);
    localparam int A3       = 3 * ANGLE_BITS;

    t_state r_state;
    logic [STEP_BITS-1:0] r_step;
    logic [31:0] r_olat, r_olon, r_odep;
    logic [ANGLE_BITS-1:0] r_ang [3];
    logic signed [31:0] r_vn, r_ve, r_vd, r_wx, r_wy, r_wz;
    logic signed [32:0] r_rx, r_ry, r_rd;
    logic signed [33:0] r_srsp, r_crsp, r_t, r_c11, r_c12, r_c13;
    logic signed [33:0] r_c21, r_c22, r_c23, r_c32, r_c33, r_m;
    logic signed [67:0] r_prod;
    logic signed [69:0] r_acc;
    logic [31:0] r_vu, r_vv, r_vw, r_pr;
    logic signed [63:0] r_n1;
    logic r_dstart, r_cstart;
    logic r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic w_acc_in, w_acc_out;
    logic [31:0] w_lat, w_lon, w_dep, w_olat, w_olon, w_odep;
    logic [2:0] w_cdone;
    logic signed [31:0] w_cos [3];
    logic signed [31:0] w_sin [3];
    logic signed [33:0] w_a, w_b;
    logic signed [69:0] w_p, w_ps, w_pd;
    logic signed [33:0] w_rp;
    logic w_d1, w_d2;
    logic signed [64:0] w_q1, w_q2;
    logic [31:0] w_rr, w_yr;

    assign w_acc_in  = s_axis_tvalid & s_axis_tready;
    assign w_acc_out = m_axis_tvalid & m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    assign w_lat = s_axis_tdata[A3+223:A3+192];
    assign w_lon = s_axis_tdata[A3+255:A3+224];
    assign w_dep = s_axis_tdata[A3+287:A3+256];
    // an all-zero origin is replaced by the item's own position
    assign w_olat = (r_olat == '0 && r_olon == '0 && r_odep == '0) ? w_lat : r_olat;
    assign w_olon = (r_olat == '0 && r_olon == '0 && r_odep == '0) ? w_lon : r_olon;
    assign w_odep = (r_olat == '0 && r_olon == '0 && r_odep == '0) ? w_dep : r_odep;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        eft_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_cstart),
            .i_angle (r_ang[g]),
            .o_done  (w_cdone[g]),
            .o_cos   (w_cos[g]),
            .o_sin   (w_sin[g])
        );
    end

    // lane 0 roll, lane 1 pitch, lane 2 yaw
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            5'd0:  begin w_a = 34'(w_sin[0]); w_b = 34'(w_sin[1]); end
            5'd1:  begin w_a = 34'(w_cos[0]); w_b = 34'(w_sin[1]); end
            5'd2:  begin w_a = 34'(w_cos[1]); w_b = 34'(w_cos[2]); end
            5'd3:  begin w_a = r_srsp;        w_b = 34'(w_cos[2]); end
            5'd4:  begin w_a = 34'(w_cos[0]); w_b = 34'(w_sin[2]); end
            5'd5:  begin w_a = r_crsp;        w_b = 34'(w_cos[2]); end
            5'd6:  begin w_a = 34'(w_sin[0]); w_b = 34'(w_sin[2]); end
            5'd7:  begin w_a = 34'(w_cos[1]); w_b = 34'(w_sin[2]); end
            5'd8:  begin w_a = r_srsp;        w_b = 34'(w_sin[2]); end
            5'd9:  begin w_a = 34'(w_cos[0]); w_b = 34'(w_cos[2]); end
            5'd10: begin w_a = r_crsp;        w_b = 34'(w_sin[2]); end
            5'd11: begin w_a = 34'(w_sin[0]); w_b = 34'(w_cos[2]); end
            5'd12: begin w_a = 34'(w_sin[0]); w_b = 34'(w_cos[1]); end
            5'd13: begin w_a = 34'(w_cos[0]); w_b = 34'(w_cos[1]); end
            5'd14: begin w_a = 34'(r_vn);     w_b = r_c11; end
            5'd15: begin w_a = 34'(r_ve);     w_b = r_c12; end
            5'd16: begin w_a = 34'(r_vd);     w_b = r_c13; end
            5'd17: begin w_a = 34'(r_vn);     w_b = r_c21; end
            5'd18: begin w_a = 34'(r_ve);     w_b = r_c22; end
            5'd19: begin w_a = 34'(r_vd);     w_b = r_c23; end
            5'd20: begin w_a = 34'(r_vn);     w_b = -34'(w_sin[1]); end
            5'd21: begin w_a = 34'(r_ve);     w_b = r_c32; end
            5'd22: begin w_a = 34'(r_vd);     w_b = r_c33; end
            5'd23: begin w_a = 34'(r_wy);     w_b = 34'(w_sin[0]); end
            5'd24: begin w_a = 34'(r_wz);     w_b = 34'(w_cos[0]); end
            5'd25: begin w_a = 34'(r_wy);     w_b = 34'(w_cos[0]); end
            5'd26: begin w_a = 34'(r_wz);     w_b = 34'(w_sin[0]); end
            5'd27: begin w_a = r_m;           w_b = 34'(w_sin[1]); end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_p  = 70'(r_prod);
    assign w_ps = r_acc + w_p;
    assign w_pd = r_acc - w_p;
    assign w_rp = 34'(rnd30(w_p));

    eft_div u_div_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_n1),
        .i_den   (w_cos[1]),
        .o_done  (w_d1),
        .o_quo   (w_q1)
    );

    eft_div u_div_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   ({r_m[33:0], 30'd0}),
        .i_den   (w_cos[1]),
        .o_done  (w_d2),
        .o_quo   (w_q2)
    );

    assign w_rr = sat32(70'(r_wx) + 70'(w_q1));
    assign w_yr = sat32(70'(w_q2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_olat   <= '0;
            r_olon   <= '0;
            r_odep   <= '0;
            r_cstart <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cstart <= (r_state == ST_IDLE) && w_acc_in;
            r_dstart <= (r_state == ST_MUL_US) && (r_step == STEP_BITS'(MUL_STEPS - 1));
            // a finished item loads the output register, else a taken one leaves it
            r_ovalid <= ((r_state == ST_DONE) && (!r_ovalid || w_acc_out))
                        || (r_ovalid && !w_acc_out);
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        r_olat   <= w_olat;
                        r_olon   <= w_olon;
                        r_odep   <= w_odep;
                        r_state  <= ST_CORDIC;
                    end
                end
                ST_CORDIC: begin
                    if (!r_cstart && (&w_cdone)) begin
                        r_step  <= '0;
                        r_state <= ST_MUL_IS;
                    end
                end
                ST_MUL_IS: r_state <= ST_MUL_US;
                ST_MUL_US: begin
                    if (r_step == STEP_BITS'(MUL_STEPS - 1)) begin
                        r_state  <= ST_DIV;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= ST_MUL_IS;
                    end
                end
                ST_DIV: begin
                    if (!r_dstart && w_d1 && w_d2) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || w_acc_out) begin
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_acc_in) begin
            r_ang[0] <= s_axis_tdata[ANGLE_BITS-1:0];
            r_ang[1] <= s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
            r_ang[2] <= s_axis_tdata[A3-1:2*ANGLE_BITS];
            r_vn <= s_axis_tdata[A3+31:A3];
            r_ve <= s_axis_tdata[A3+63:A3+32];
            r_vd <= s_axis_tdata[A3+95:A3+64];
            r_wx <= s_axis_tdata[A3+127:A3+96];
            r_wy <= s_axis_tdata[A3+159:A3+128];
            r_wz <= s_axis_tdata[A3+191:A3+160];
            r_rx <= 33'(signed'(w_lat)) - 33'(signed'(w_olat));
            r_ry <= 33'(signed'(w_lon)) - 33'(signed'(w_olon));
            r_rd <= 33'(signed'(w_dep)) - 33'(signed'(w_odep));
        end
        if (r_state == ST_MUL_IS) begin
            r_prod <= w_a * w_b;
        end
        if (r_state == ST_MUL_US) begin
            case (r_step)
                5'd0:  r_srsp <= w_rp;
                5'd1:  r_crsp <= w_rp;
                5'd2:  r_c11  <= w_rp;
                5'd3:  r_t    <= w_rp;
                5'd4:  r_c12  <= r_t - w_rp;
                5'd5:  r_t    <= w_rp;
                5'd6:  r_c13  <= r_t + w_rp;
                5'd7:  r_c21  <= w_rp;
                5'd8:  r_t    <= w_rp;
                5'd9:  r_c22  <= r_t + w_rp;
                5'd10: r_t    <= w_rp;
                5'd11: r_c23  <= r_t - w_rp;
                5'd12: r_c32  <= w_rp;
                5'd13: r_c33  <= w_rp;
                5'd14, 5'd17, 5'd20, 5'd23, 5'd25: r_acc <= w_p;
                5'd15, 5'd18, 5'd21: r_acc <= w_ps;
                5'd16: r_vu <= sat32(70'(rnd30(w_ps)));
                5'd19: r_vv <= sat32(70'(rnd30(w_ps)));
                5'd22: r_vw <= sat32(70'(rnd30(w_ps)));
                5'd24: r_m  <= 34'(rnd30(w_ps));
                5'd26: r_pr <= sat32(70'(rnd30(w_pd)));
                5'd27: r_n1 <= w_p[63:0];
                default: r_t <= r_t;
            endcase
        end
        if (r_state == ST_DONE && (!r_ovalid || w_acc_out)) begin
            r_odata <= OUT_W'({w_yr, r_pr, w_rr, r_vw, r_vv, r_vu,
                               r_ang[2], r_ang[1], r_ang[0], r_rd, r_ry, r_rx});
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

@@ sim/euler_frame_transform_tb.sv @@
// self-checking bench for euler_frame_transform: directed table, then random navigation samples
// depends on eft_pkg and the euler_frame_transform top level
module euler_frame_transform_tb;
    import eft_pkg::*;

    localparam int ANGLE_W   = 16;
    localparam int RAND_CNT  = 1400;
    localparam int CALM_FROM = 1200;

    // packed so that roll lands in the lowest bits
    typedef struct packed {
        logic signed [31:0] depth_mm;
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [31:0] rate_z;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_x;
        logic signed [31:0] vel_down;
        logic signed [31:0] vel_east;
        logic signed [31:0] vel_north;
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
    } t_nav_sample;

    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] yaw_rate;
        logic [31:0] pitch_rate;
        logic [31:0] roll_rate;
        logic [31:0] vel_w;
        logic [31:0] vel_v;
        logic [31:0] vel_u;
        logic [ANGLE_W-1:0] yaw_out;
        logic [ANGLE_W-1:0] pitch_out;
        logic [ANGLE_W-1:0] roll_out;
        logic [32:0] rel_depth;
        logic [32:0] rel_y;
        logic [32:0] rel_x;
    } t_frame_out;

    typedef struct {
        t_nav_sample smp;
        bit          typed;   // expected relative position given by hand
        logic [32:0] rel_x;
        logic [32:0] rel_y;
        logic [32:0] rel_depth;
    } t_table_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    t_nav_sample s_axis_tdata = '0;    // roll, pitch, yaw, vel n/e/d, rates x/y/z, lat, lon, depth
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    t_frame_out  m_axis_tdata;         // rel x/y/depth, angles, vel u/v/w, rates p/q/r

    t_frame_out  expected_frames[$];
    logic [31:0] org_lat, org_lon, org_depth;
    int          errors = 0;
    int          frames_seen = 0;
    bit          calm = 1'b0;
    bit          send_done = 1'b0;

    const longint unsigned atan_turn[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10680862, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41721,
        20860, 10430, 5215, 2607, 1303,
        651, 325, 162, 81, 40,
        20, 10, 5, 2, 1};

    euler_frame_transform uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("euler_frame_transform verification failed");
        $finish;
    end

    function automatic longint round_q30(longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint div_clamped(longint n, longint d);
        if (d == 0) begin
            if (n > 0) return 64'sh3fff_ffff_ffff_ffff;
            if (n < 0) return -64'sh4000_0000_0000_0000;
            return 64'sd0;
        end
        return n / d;
    endfunction

    task automatic cordic_sincos(input logic [ANGLE_W-1:0] ang, output longint c,
                                 output longint s);
        logic [31:0] a, probe;
        longint      x, y, z, nx;
        bit          flip;
        a = {ang, {(32-ANGLE_W){1'b0}}};
        probe = a + 32'h4000_0000;
        flip = probe[31];
        if (flip) a = a + 32'h8000_0000;
        z = longint'($signed(a));
        x = 64'sd652032874;
        y = 64'sd0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(atan_turn[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(atan_turn[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // latches the origin on an all-zero one and forms the rotated frame
    task automatic transform_sample(input t_nav_sample d, output t_frame_out f);
        longint sr, cr, sp, cp, sy, cy, vn, ve, vd, wx, wy, wz;
        longint c11, c12, c13, c21, c22, c23, c31, c32, c33, srsp, crsp, m, t;
        if (org_lat == 0 && org_lon == 0 && org_depth == 0) begin
            org_lat = d.latitude;
            org_lon = d.longitude;
            org_depth = d.depth_mm;
        end
        f = '0;
        t = longint'(d.latitude) - longint'($signed(org_lat));
        f.rel_x = t[32:0];
        t = longint'(d.longitude) - longint'($signed(org_lon));
        f.rel_y = t[32:0];
        t = longint'(d.depth_mm) - longint'($signed(org_depth));
        f.rel_depth = t[32:0];
        f.roll_out = d.roll;
        f.pitch_out = d.pitch;
        f.yaw_out = d.yaw;
        cordic_sincos(d.roll, cr, sr);
        cordic_sincos(d.pitch, cp, sp);
        cordic_sincos(d.yaw, cy, sy);
        vn = longint'(d.vel_north); ve = longint'(d.vel_east); vd = longint'(d.vel_down);
        wx = longint'(d.rate_x); wy = longint'(d.rate_y); wz = longint'(d.rate_z);
        srsp = round_q30(sr * sp);
        crsp = round_q30(cr * sp);
        c11 = round_q30(cp * cy);
        c12 = round_q30(srsp * cy) - round_q30(cr * sy);
        c13 = round_q30(crsp * cy) + round_q30(sr * sy);
        c21 = round_q30(cp * sy);
        c22 = round_q30(srsp * sy) + round_q30(cr * cy);
        c23 = round_q30(crsp * sy) - round_q30(sr * cy);
        c31 = -sp;
        c32 = round_q30(sr * cp);
        c33 = round_q30(cr * cp);
        f.vel_u = clamp32(round_q30(vn * c11 + ve * c12 + vd * c13));
        f.vel_v = clamp32(round_q30(vn * c21 + ve * c22 + vd * c23));
        f.vel_w = clamp32(round_q30(vn * c31 + ve * c32 + vd * c33));
        m = round_q30(wy * sr + wz * cr);
        f.roll_rate = clamp32(wx + div_clamped(m * sp, cp));
        f.pitch_rate = clamp32(round_q30(wy * cr - wz * sr));
        f.yaw_rate = clamp32(div_clamped(m * 64'sd1073741824, cp));
    endtask

    function automatic t_nav_sample random_sample();
        t_nav_sample d;
        d.roll = 16'($urandom);
        d.pitch = 16'($urandom);
        d.yaw = 16'($urandom);
        d.vel_north = $urandom;
        d.vel_east = $urandom;
        d.vel_down = $urandom;
        d.rate_x = $urandom;
        d.rate_y = $urandom;
        d.rate_z = $urandom;
        d.latitude = int'($urandom_range(3600000000, 0)) - 1800000000;
        d.longitude = int'($urandom_range(3600000000, 0)) - 1800000000;
        d.depth_mm = $urandom;
        // pitch near straight up or down stresses the rate division
        if ($urandom_range(7, 0) == 0)
            d.pitch = ($urandom_range(1, 0) ? 16'sd16384 : -16'sd16384)
                      + $signed(16'($urandom_range(6, 0))) - 16'sd3;
        // small values keep the outputs off saturation
        if ($urandom_range(1, 0)) begin
            d.vel_north = $signed(d.vel_north) >>> 12;
            d.vel_east = $signed(d.vel_east) >>> 12;
            d.vel_down = $signed(d.vel_down) >>> 12;
            d.rate_x = $signed(d.rate_x) >>> 12;
            d.rate_y = $signed(d.rate_y) >>> 12;
            d.rate_z = $signed(d.rate_z) >>> 12;
        end
        return d;
    endfunction

    function automatic t_nav_sample mk(int r, int p, int y, int vn, int ve, int vd,
                                       int wx, int wy, int wz, int lat, int lon, int dep);
        t_nav_sample d;
        d.roll = 16'(r); d.pitch = 16'(p); d.yaw = 16'(y);
        d.vel_north = vn; d.vel_east = ve; d.vel_down = vd;
        d.rate_x = wx; d.rate_y = wy; d.rate_z = wz;
        d.latitude = lat; d.longitude = lon; d.depth_mm = dep;
        return d;
    endfunction

    task automatic offer(input t_nav_sample d, input bit typed, input t_table_row row);
        t_frame_out f;
        int gap;
        if (!calm && $urandom_range(2, 0) == 0) begin
            gap = int'($urandom_range(10, 1));
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        transform_sample(d, f);
        if (typed) begin
            f.rel_x = row.rel_x;
            f.rel_y = row.rel_y;
            f.rel_depth = row.rel_depth;
            f.roll_out = d.roll;
            f.pitch_out = d.pitch;
            f.yaw_out = d.yaw;
        end
        expected_frames.push_back(f);
    endtask

    // sender
    initial begin
        t_table_row rows[$];
        t_table_row row;
        org_lat = '0; org_lon = '0; org_depth = '0;
        // all-zero position keeps the origin clear, so the next one latches
        row = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(-32768, 0, 32767, 65536, 0, 0, 0, 0, 0, 1800000000, -1800000000,
                   32'h8000_0000), 1'b1, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, -1800000000, 1800000000, 32'h7fff_ffff),
                1'b1, -33'sd3600000000, 33'sd3600000000, 33'sd4294967295};
        rows.push_back(row);
        row = '{mk(32767, -32768, -32768, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1800000000, -1800000000,
                   32'h8000_0000), 1'b1, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(-32768, 32767, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        // pitch at plus and minus ninety degrees, with and without rate numerator
        row = '{mk(8192, 16384, 4096, 65536, -65536, 131072, 65536, 0, 0, 1, 2, 3),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(8192, -16384, 4096, 65536, -65536, 131072, 65536, 0, 0, 1, 2, 3),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(5000, 16384, -7000, 1, 2, 3, 1000, 65536, -65536, 4, 5, 6),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(-5000, -16384, 7000, 1, 2, 3, -1000, -65536, 65536, 4, 5, 6),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(0, 16383, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 7, 8, 9),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(16384, 16385, -16384, 65536, 65536, 65536, 1, 2, 3, 7, 8, 9),
                1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);
        row = '{mk(-1, 1, -1, -1, 1, -1, -1, 1, -1, -1, 1, -1), 1'b0, 33'd0, 33'd0, 33'd0};
        rows.push_back(row);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) offer(rows[i].smp, rows[i].typed, rows[i]);
        for (int n = 0; n < RAND_CNT; n++) begin
            if (n == CALM_FROM) calm = 1'b1;
            offer(random_sample(), 1'b0, row);
        end
        s_axis_tvalid <= 1'b0;
        send_done = 1'b1;
    end

    // receiver: random stall bursts and one long hold-off that backs up the block
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && frames_seen >= 100) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (2000) @(posedge i_clk);
            end
            if (!calm && $urandom_range(2, 0) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 1)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frame_out e, g;
        logic [32:0] ev[12], gv[12];
        string names[12];
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            frames_seen++;
            g = m_axis_tdata;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected item %h", $time, g);
            end else begin
                e = expected_frames.pop_front();
                names = '{"rel_x", "rel_y", "rel_depth", "roll_out", "pitch_out", "yaw_out",
                          "vel_u", "vel_v", "vel_w", "roll_rate", "pitch_rate", "yaw_rate"};
                ev = '{e.rel_x, e.rel_y, e.rel_depth, 33'(e.roll_out), 33'(e.pitch_out),
                       33'(e.yaw_out), 33'(e.vel_u), 33'(e.vel_v), 33'(e.vel_w),
                       33'(e.roll_rate), 33'(e.pitch_rate), 33'(e.yaw_rate)};
                gv = '{g.rel_x, g.rel_y, g.rel_depth, 33'(g.roll_out), 33'(g.pitch_out),
                       33'(g.yaw_out), 33'(g.vel_u), 33'(g.vel_v), 33'(g.vel_w),
                       33'(g.roll_rate), 33'(g.pitch_rate), 33'(g.yaw_rate)};
                for (int k = 0; k < 12; k++) begin
                    if (ev[k] !== gv[k]) begin
                        errors++;
                        $display("%0t: %s expected %h got %h", $time, names[k], ev[k], gv[k]);
                    end
                end
            end
        end
    end

    initial begin
        wait (send_done);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("euler_frame_transform verification clean");
        end else begin
            $display("euler_frame_transform verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/eft_pkg.sv
src/eft_cordic.sv
src/eft_div.sv
src/euler_frame_transform.sv
sim/euler_frame_transform_tb.sv
